// ===== rtl/core/bgm_pkg.sv =====
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared types, codes and reset values for the battery guard mode block.
// ----------------------------------------------------------------------------
`default_nettype none

package bgm_pkg;

    // Field widths fixed by the interface definition
    localparam int TEMP_W     = 12;
    localparam int FAULT_W    = 3;
    localparam int LIMIT_W    = 15;
    localparam int LEVEL_W    = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int OUT_W      = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_LIMIT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_BAND      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_WARN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ENERGY_WARN    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ENERGY_FAULT   = 3'd4;

    // Register reset values
    localparam logic [LIMIT_W-1:0]        RST_CURRENT_LIMIT = 15'd20000;
    localparam logic [LIMIT_W-1:0]        RST_IDLE_BAND     = 15'd10;
    localparam logic signed [TEMP_W-1:0]  RST_TEMP_WARN     = 12'sd550;
    localparam logic [LEVEL_W-1:0]        RST_ENERGY_WARN   = 48'd1000000000;
    localparam logic [LEVEL_W-1:0]        RST_ENERGY_FAULT  = 48'd2000000000;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE        = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_OVERCURRENT = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVERTEMP    = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_UNDERVOLT   = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_OVERVOLT    = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_DISCH  = 2'd1,
        MODE_CHARGE = 2'd2,
        MODE_FAULT  = 2'd3
    } t_mode;

    // Per-item decisions made in the front stage
    typedef struct packed {
        logic               kind;
        logic               over;    // |current| above the limit
        logic               pos;     // current above +band
        logic               neg;     // current below -band
        logic               hot;     // temperature at or above warn level
        logic [FAULT_W-1:0] mfault;  // model fault, codes above overvolt folded
    } t_front;

endpackage

`default_nettype wire

// ===== rtl/core/bgm_front.sv =====
// ----------------------------------------------------------------------------
// bgm_front
// Input register stage: captures a sample, squares its magnitude and
// resolves all compares that do not depend on the running state.
// ----------------------------------------------------------------------------
`default_nettype none

module bgm_front #(
    parameter int CURRENT_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire                                  i_kind,
    input  wire  signed [CURRENT_BITS-1:0]       i_current,
    input  wire  signed [bgm_pkg::TEMP_W-1:0]    i_cell_temp,
    input  wire         [bgm_pkg::FAULT_W-1:0]   i_model_fault,
    input  wire         [bgm_pkg::LIMIT_W-1:0]   i_current_limit,
    input  wire         [bgm_pkg::LIMIT_W-1:0]   i_idle_band,
    input  wire  signed [bgm_pkg::TEMP_W-1:0]    i_temp_warn,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output bgm_pkg::t_front                      o_item,
    output logic        [2*CURRENT_BITS-1:0]     o_sq
);
    import bgm_pkg::*;

    localparam int KW = ((CURRENT_BITS > LIMIT_W) ? CURRENT_BITS : LIMIT_W) + 2;

    logic                      r_valid;
    t_front                    r_item;
    logic [2*CURRENT_BITS-1:0] r_sq;
    t_front                    n_item;
    logic [2*CURRENT_BITS-1:0] n_sq;

    logic signed [KW-1:0]        cur_x;
    logic signed [KW-1:0]        band_x;
    logic signed [KW-1:0]        limit_x;
    logic signed [KW-1:0]        mag_x;
    logic        [CURRENT_BITS-1:0] mag;
    logic                        load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        cur_x   = KW'(i_current);
        band_x  = signed'(KW'(i_idle_band));
        limit_x = signed'(KW'(i_current_limit));
        mag_x   = (cur_x < 0) ? -cur_x : cur_x;
        mag     = mag_x[CURRENT_BITS-1:0];
        n_sq    = (2*CURRENT_BITS)'(mag) * (2*CURRENT_BITS)'(mag);

        n_item.kind   = i_kind;
        n_item.over   = mag_x > limit_x;
        n_item.pos    = cur_x > band_x;
        n_item.neg    = cur_x < -band_x;
        n_item.hot    = i_cell_temp >= i_temp_warn;
        // fold undefined model codes into overvoltage
        n_item.mfault = (i_model_fault > FAULT_OVERVOLT) ? FAULT_OVERVOLT : i_model_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
            r_sq   <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_sq    = r_sq;

endmodule

`default_nettype wire

// ===== rtl/core/bgm_core.sv =====
// ----------------------------------------------------------------------------
// bgm_core
// Mode state machine, fault latch, sticky warning, saturating energy sum
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgm_core #(
    parameter int CURRENT_BITS = 16,
    parameter int ENERGY_BITS  = 48
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  bgm_pkg::t_front                   i_item,
    input  wire  [2*CURRENT_BITS-1:0]         i_sq,
    input  wire  [bgm_pkg::LEVEL_W-1:0]       i_energy_warn,
    input  wire  [bgm_pkg::LEVEL_W-1:0]       i_energy_fault,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [bgm_pkg::OUT_W-1:0]         o_data
);
    import bgm_pkg::*;

    localparam int SW   = ((ENERGY_BITS > 2*CURRENT_BITS) ? ENERGY_BITS : 2*CURRENT_BITS) + 1;
    localparam int CMPW = (ENERGY_BITS > LEVEL_W) ? ENERGY_BITS : LEVEL_W;
    localparam logic [SW-1:0] EMAX = SW'({ENERGY_BITS{1'b1}});

    t_mode                  r_mode, n_mode;
    logic [FAULT_W-1:0]     r_fault, n_fault;
    logic                   r_warn, n_warn;
    logic [ENERGY_BITS-1:0] r_sum, n_sum;
    logic                   n_acc;

    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out;
    t_mode                  out_mode;

    logic                   take;
    logic [SW-1:0]          wide_sum;
    logic [ENERGY_BITS-1:0] sat_sum;
    logic                   warn_hit;
    logic                   fault_hit;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        wide_sum  = SW'(r_sum) + SW'(i_sq);
        sat_sum   = (wide_sum > EMAX) ? {ENERGY_BITS{1'b1}} : wide_sum[ENERGY_BITS-1:0];
        warn_hit  = CMPW'(sat_sum) >= CMPW'(i_energy_warn);
        fault_hit = CMPW'(sat_sum) >= CMPW'(i_energy_fault);
    end

    always_comb begin
        n_mode  = r_mode;
        n_fault = r_fault;
        n_warn  = r_warn;
        n_sum   = r_sum;
        n_acc   = 1'b1;
        if (take) begin
            if (i_item.kind == KIND_CLEAR) begin
                n_mode  = MODE_IDLE;
                n_fault = FAULT_NONE;
                n_warn  = 1'b0;
                n_sum   = '0;
            end else if (r_mode != MODE_FAULT && r_fault == FAULT_NONE) begin
                if (i_item.over) begin
                    n_mode  = MODE_FAULT;
                    n_fault = FAULT_OVERCURRENT;
                    n_acc   = 1'b0;
                end else begin
                    n_sum = sat_sum;
                    if (i_item.hot || warn_hit) begin
                        n_warn = 1'b1;
                    end
                    if (i_item.mfault != FAULT_NONE) begin
                        n_mode  = MODE_FAULT;
                        n_fault = i_item.mfault;
                    end else if (fault_hit) begin
                        n_mode  = MODE_FAULT;
                        n_fault = FAULT_OVERTEMP;
                    end else begin
                        unique case (r_mode)
                            MODE_IDLE: begin
                                if (i_item.pos) begin
                                    n_mode = MODE_DISCH;
                                end else if (i_item.neg) begin
                                    n_mode = MODE_CHARGE;
                                end
                            end
                            MODE_DISCH: begin
                                if (!i_item.pos) begin
                                    n_mode = MODE_IDLE;
                                end
                            end
                            MODE_CHARGE: begin
                                if (!i_item.neg) begin
                                    n_mode = MODE_IDLE;
                                end
                            end
                            default: begin
                                n_mode = r_mode;
                            end
                        endcase
                    end
                end
            end
        end
        out_mode = (n_fault != FAULT_NONE) ? MODE_FAULT : n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_fault <= FAULT_NONE;
            r_warn  <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_fault <= n_fault;
            r_warn  <= n_warn;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= {1'b0, n_acc, n_warn, n_fault, out_mode};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/battery_guard_mode_fsm.sv =====
// ----------------------------------------------------------------------------
// battery_guard_mode_fsm
// Battery guard: idle/discharge/charge mode tracking with fault latch,
// sticky warning and a saturating current-squared energy sum.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_axis channel, one transfer per sample; tuser
//   carries the item kind (sample or clear). Each transfer yields exactly
//   one result transfer on m_axis with mode, fault code, warning and the
//   accepted flag. Thresholds are written through the cfg channel, which is
//   always ready; write them only while no item is in flight.
//   An input transfer passes the front register, then the result register,
//   before its result can transfer. Throughput: one item per cycle while
//   m_axis_tready is high; the state update for one item completes in the
//   same cycle it enters the result register, so the next item sees it immediately.
//   Reset (synchronous, active low) returns the thresholds to their defaults,
//   clears mode, fault, warning and energy sum, and empties both stages.
//   When m_axis_tready is low the result holds in its register; an empty
//   front register takes at most one more transfer, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_guard_mode_fsm #(
    parameter int CURRENT_BITS = 16,
    parameter int ENERGY_BITS  = 48
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Sample stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, lowest bit up: current, cell_temp, model_fault, zero pad
    input  wire  [((CURRENT_BITS+bgm_pkg::TEMP_W+bgm_pkg::FAULT_W+7)/8)*8-1:0] s_axis_tdata,
    // tuser: kind
    input  wire                                s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // tdata, lowest bit up: mode[1:0], fault_kind[4:2], warning[5],
    // accepted[6], zero pad[7]
    output logic [bgm_pkg::OUT_W-1:0]          m_axis_tdata,
    // Configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [bgm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [bgm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bgm_pkg::*;

    localparam int TEMP_LSB  = CURRENT_BITS;
    localparam int FAULT_LSB = CURRENT_BITS + TEMP_W;

    // Threshold registers
    logic [LIMIT_W-1:0]        r_current_limit;
    logic [LIMIT_W-1:0]        r_idle_band;
    logic signed [TEMP_W-1:0]  r_temp_warn;
    logic [LEVEL_W-1:0]        r_energy_warn;
    logic [LEVEL_W-1:0]        r_energy_fault;

    logic                      cfg_write;

    // Front to core
    logic                      front_valid;
    logic                      core_ready;
    t_front                    front_item;
    logic [2*CURRENT_BITS-1:0] front_sq;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Decode the write; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit <= RST_CURRENT_LIMIT;
            r_idle_band     <= RST_IDLE_BAND;
            r_temp_warn     <= RST_TEMP_WARN;
            r_energy_warn   <= RST_ENERGY_WARN;
            r_energy_fault  <= RST_ENERGY_FAULT;
        end else if (cfg_write) begin
            unique case (i_cfg_addr)
                REG_CURRENT_LIMIT: r_current_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_IDLE_BAND:     r_idle_band     <= i_cfg_data[LIMIT_W-1:0];
                REG_TEMP_WARN:     r_temp_warn     <= signed'(i_cfg_data[TEMP_W-1:0]);
                REG_ENERGY_WARN:   r_energy_warn   <= i_cfg_data[LEVEL_W-1:0];
                REG_ENERGY_FAULT:  r_energy_fault  <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                    r_current_limit <= r_current_limit;
                end
            endcase
        end
    end

    // Capture the sample and resolve state-independent compares
    bgm_front #(
        .CURRENT_BITS (CURRENT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_kind          (s_axis_tuser),
        .i_current       (signed'(s_axis_tdata[CURRENT_BITS-1:0])),
        .i_cell_temp     (signed'(s_axis_tdata[TEMP_LSB +: TEMP_W])),
        .i_model_fault   (s_axis_tdata[FAULT_LSB +: FAULT_W]),
        .i_current_limit (r_current_limit),
        .i_idle_band     (r_idle_band),
        .i_temp_warn     (r_temp_warn),
        .o_valid         (front_valid),
        .i_ready         (core_ready),
        .o_item          (front_item),
        .o_sq            (front_sq)
    );

    // Advance the state and register the result
    bgm_core #(
        .CURRENT_BITS (CURRENT_BITS),
        .ENERGY_BITS  (ENERGY_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (front_valid),
        .o_ready        (core_ready),
        .i_item         (front_item),
        .i_sq           (front_sq),
        .i_energy_warn  (r_energy_warn),
        .i_energy_fault (r_energy_fault),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bgm_checker.sv =====
// ----------------------------------------------------------------------------
// bgm_checker
// Port-level checks on the result stream of the battery guard block.
// ----------------------------------------------------------------------------
`default_nettype none

module bgm_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [bgm_pkg::OUT_W-1:0]    m_axis_tdata
);
    import bgm_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Fault mode shown exactly when a fault code is latched
    a_mode_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[1:0] == MODE_FAULT) == (m_axis_tdata[4:2] != FAULT_NONE)))
        else $error("mode and fault code disagree");

    // A rejected sample always reports an overcurrent fault
    a_reject_oc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[4:2] == FAULT_OVERCURRENT)
        else $error("rejected sample without overcurrent fault");

endmodule

bind battery_guard_mode_fsm bgm_checker u_bgm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
